// ===== src/ogcd_pkg.sv =====
// ogcd_pkg: shared types and constants for the occupancy grid change detector
// no dependencies; imported by every module of the block except ogcd_ram
`default_nettype none

package ogcd_pkg;

	// largest grid side supported by the cell store
	localparam int MAX_SIDE_DEF = 256;

	// field widths fixed by the interface
	localparam int CFG_W  = 9;
	localparam int THR_W  = 7;
	localparam int OCC_W  = 8;
	localparam int POS_W  = 8;
	localparam int IDX_W  = 2;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// register reset values
	localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 9'd256;
	localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 9'd256;
	localparam logic [THR_W-1:0] FREE_THR_RST    = 7'd25;

	// occupancy code for an unknown cell
	localparam logic signed [OCC_W-1:0] OCC_UNKNOWN = -8'sd1;

	typedef enum logic [1:0] {
		CLASS_FREE    = 2'd0,
		CLASS_WALL    = 2'd1,
		CLASS_UNKNOWN = 2'd2
	} cell_class_t;

	typedef enum logic [IDX_W-1:0] {
		REG_GRID_WIDTH     = 2'd0,
		REG_GRID_HEIGHT    = 2'd1,
		REG_FREE_THRESHOLD = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/ogcd_ram.sv =====
// ogcd_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ogcd_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/ogcd_fifo.sv =====
// ogcd_fifo: small register queue between the front and back parts
// depends on ogcd_pkg; depth must be a power of two, at least two
`default_nettype none

module ogcd_fifo
	import ogcd_pkg::*;
#(
	parameter int WIDTH = 18,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic      [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/ogcd_front.sv =====
// ogcd_front: configuration registers, raster position counters and classification
// depends on ogcd_pkg; feeds cell updates into ogcd_fifo
`default_nettype none

module ogcd_front
	import ogcd_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	localparam int SIDE_W  = $clog2(MAX_SIDE),
	localparam int ENTRY_W = 2 * SIDE_W + 2
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_wdata,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [OCC_W-1:0]  occupancy,
	input  wire logic                     first_of_grid,
	input  wire logic                     clr_busy,
	output logic                          push_valid,
	input  wire logic                     push_ready,
	output logic          [ENTRY_W-1:0]   push_data
);

	// wide enough for both the register and the largest side
	localparam int CW = (SIDE_W + 1 > CFG_W) ? SIDE_W + 1 : CFG_W;
	localparam logic [CW-1:0]     SIDE_MAX_CW = CW'(MAX_SIDE);
	localparam logic [SIDE_W:0]   SIDE_MAX    = (SIDE_W + 1)'(MAX_SIDE);

	logic [CFG_W-1:0]  grid_width_q, grid_height_q;
	logic [THR_W-1:0]  free_thr_q;
	logic [SIDE_W-1:0] col_q;
	logic [SIDE_W:0]   row_q;

	logic [SIDE_W:0]   eff_width, eff_height;
	logic [SIDE_W-1:0] col_cur;
	logic [SIDE_W:0]   row_cur;
	logic [SIDE_W:0]   col_inc;
	logic              past_grid, accept;
	cell_class_t       cls;

	// clamp a side register to 1 .. MAX_SIDE
	function automatic logic [SIDE_W:0] clamp_side(input logic [CFG_W-1:0] v);
		logic [CW-1:0] ext;
		ext = CW'(v);
		if (ext == '0) begin
			return (SIDE_W + 1)'(1);
		end else if (ext > SIDE_MAX_CW) begin
			return SIDE_MAX;
		end else begin
			return (SIDE_W + 1)'(ext);
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			free_thr_q    <= FREE_THR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_WIDTH:     grid_width_q  <= cfg_wdata;
				REG_GRID_HEIGHT:    grid_height_q <= cfg_wdata;
				REG_FREE_THRESHOLD: free_thr_q    <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_width  = clamp_side(grid_width_q);
		eff_height = clamp_side(grid_height_q);
		col_cur    = first_of_grid ? '0 : col_q;
		row_cur    = first_of_grid ? '0 : row_q;
		past_grid  = (row_cur >= eff_height);
		col_inc    = {1'b0, col_cur} + 1'b1;

		if (occupancy == OCC_UNKNOWN) begin
			cls = CLASS_UNKNOWN;
		end else if (occupancy < $signed({1'b0, free_thr_q})) begin
			cls = CLASS_FREE;
		end else begin
			cls = CLASS_WALL;
		end
	end

	assign in_ready   = push_ready && !clr_busy;
	assign accept     = in_valid && in_ready;
	// cells past the grid are dropped here
	assign push_valid = accept && !past_grid;
	assign push_data  = {row_cur[SIDE_W-1:0], col_cur, cls};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && !past_grid) begin
			if (col_inc >= eff_width) begin
				col_q <= '0;
				row_q <= row_cur + 1'b1;
			end else begin
				col_q <= col_inc[SIDE_W-1:0];
				row_q <= row_cur;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/ogcd_back.sv =====
// ogcd_back: cell store read-compare-write, clearing pass and result register
// depends on ogcd_pkg and ogcd_ram; takes cell updates from ogcd_fifo
`default_nettype none

module ogcd_back
	import ogcd_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	localparam int SIDE_W  = $clog2(MAX_SIDE),
	localparam int ENTRY_W = 2 * SIDE_W + 2,
	localparam int AW      = 2 * SIDE_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pop_valid,
	output logic                    pop_ready,
	input  wire logic [ENTRY_W-1:0] pop_data,
	output logic                    clr_busy,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [POS_W-1:0]   row,
	output logic      [POS_W-1:0]   col,
	output logic      [1:0]         cell_class
);

	logic              clr_busy_q;
	logic [AW-1:0]     clr_addr_q;

	logic              valid_s1;
	logic [SIDE_W-1:0] row_s1, col_s1;
	cell_class_t       cls_s1;
	logic              fwd_hit_s1;
	cell_class_t       fwd_cls_s1;

	logic              out_valid_q;
	logic [POS_W-1:0]  row_q, col_q;
	cell_class_t       cls_q;

	logic [AW-1:0]     in_addr, addr_s1, waddr;
	cell_class_t       in_cls, old_cls;
	logic [1:0]        ram_rdata, wdata;
	logic              out_free, change, s1_go, s1_take, pop, we;

	assign in_addr = pop_data[ENTRY_W-1:2];
	assign in_cls  = cell_class_t'(pop_data[1:0]);
	assign addr_s1 = {row_s1, col_s1};

	// a write to the same cell in the cycle of the read is forwarded
	assign old_cls  = fwd_hit_s1 ? fwd_cls_s1 : cell_class_t'(ram_rdata);
	assign change   = (old_cls != cls_s1);
	assign out_free = !out_valid_q || out_ready;
	assign s1_go    = valid_s1 && (!change || out_free);
	assign s1_take  = !clr_busy_q && (!valid_s1 || s1_go);
	assign pop_ready = s1_take;
	assign pop      = pop_valid && s1_take;

	assign we    = clr_busy_q || (s1_go && change);
	assign waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign wdata = clr_busy_q ? CLASS_UNKNOWN : cls_s1;

	ogcd_ram #(
		.WIDTH (2),
		.DEPTH (1 << AW)
	) u_cell_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (pop),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	// clearing pass over every entry after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			row_s1     <= pop_data[ENTRY_W-1:SIDE_W+2];
			col_s1     <= pop_data[SIDE_W+1:2];
			cls_s1     <= in_cls;
			fwd_hit_s1 <= s1_go && (in_addr == addr_s1);
			fwd_cls_s1 <= cls_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && change) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && change) begin
			row_q <= POS_W'(row_s1);
			col_q <= POS_W'(col_s1);
			cls_q <= cls_s1;
		end
	end

	assign clr_busy   = clr_busy_q;
	assign out_valid  = out_valid_q;
	assign row        = row_q;
	assign col        = col_q;
	assign cell_class = cls_q;

endmodule

`default_nettype wire

// ===== src/occupancy_grid_change_detector_core.sv =====
// occupancy_grid_change_detector_core: top level of the occupancy grid change detector
// depends on ogcd_pkg, ogcd_front, ogcd_fifo, ogcd_back (and ogcd_ram below it)
//
// channel  | handshake             | payload
// ---------+-----------------------+----------------------------------
// cfg      | cfg_wr_en             | cfg_index, cfg_wdata
// in       | in_valid / in_ready   | occupancy, first_of_grid
// out      | out_valid / out_ready | row, col, cell_class
//
// one grid value per cycle while out_ready is high and no clearing pass runs;
// a change reaches out through the queue, store read and result register
// after reset a clearing pass writes unknown to every cell store entry, one a
// cycle, over 2**(2*clog2(MAX_SIDE)) entries, 65536 at the default; in_ready stays low
// stalls on out back up through the result register, store stage and queue
// values past the last row are taken and dropped in the front without a result
`default_nettype none

module occupancy_grid_change_detector_core
	import ogcd_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration writes
	input  wire logic                    cfg_wr_en,
	input  wire logic [IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_wdata,
	// grid values in raster order
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [OCC_W-1:0] occupancy,
	input  wire logic                    first_of_grid,
	// changed cells
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [POS_W-1:0]             row,
	output logic [POS_W-1:0]             col,
	output logic [1:0]                   cell_class
);

	// cell update: row, column and new class
	localparam int SIDE_W  = $clog2(MAX_SIDE);
	localparam int ENTRY_W = 2 * SIDE_W + 2;

	logic               clr_busy;
	logic               push_valid, push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               pop_valid, pop_ready;
	logic [ENTRY_W-1:0] pop_data;

	// front: registers, position counters, classification, past-grid drop
	ogcd_front #(
		.MAX_SIDE (MAX_SIDE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.occupancy     (occupancy),
		.first_of_grid (first_of_grid),
		.clr_busy      (clr_busy),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	// short queue so front and back stall independently
	ogcd_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: store read, compare, write on change, result register
	ogcd_back #(
		.MAX_SIDE (MAX_SIDE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.clr_busy   (clr_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.row        (row),
		.col        (col),
		.cell_class (cell_class)
	);

endmodule

`default_nettype wire
